/* rtl/rrp_pkg.sv */
package rrp_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 32;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int ARG_NUM_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARG_COUNT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BULK_LENGTH = 8'd1;

    localparam logic [15:0] MAX_ARG_COUNT_RST   = 16'd1024;
    localparam logic [31:0] MAX_BULK_LENGTH_RST = 32'd536870912;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int LEVEL_W    = FIFO_PTR_W + 1;
    localparam logic [LEVEL_W-1:0] READY_LIMIT = LEVEL_W'(FIFO_DEPTH - 2);

    typedef struct packed {
        logic                 arg_byte_valid;
        logic [7:0]           arg_byte;
        logic                 arg_end;
        logic                 command_end;
        logic [ARG_NUM_W-1:0] arg_number;
        logic                 protocol_error;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        item_t      item0;
        item_t      item1;
    } push_t;

endpackage

/* rtl/resp_request_parser_unit.sv */
// Byte-serial request parser for RESP framing.
// Input channel (s_valid/s_ready): one stream byte per transaction, with
// s_new_connection set on the first byte of a new connection to clear all
// parse state and any latched protocol error.
// Result channel (m_valid/m_ready): one result item per transaction; a byte
// yields zero, one or two items, and m_last marks the final one of a byte.
// Configuration channel (cfg_valid/cfg_ready): index 0 sets max_arg_count,
// index 1 sets max_bulk_length; cfg_ready is always high. Write only idle.
// Path: an accepted byte is registered, parsed combinationally and written
// into the four-entry result queue, whose head drives the result port.
// Throughput: one byte per cycle while s_ready is high; bytes yielding two
// items leave the result port at one item per cycle while m_ready is high.
// Reset clears the parser to idle, restores the default limits and empties
// the result queue. When the receiver stalls, the queue fills and s_ready
// drops once fewer than two free entries would remain for the next byte.
module resp_request_parser_unit
    import rrp_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_stream_byte,
    input  logic                   s_new_connection,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_arg_byte_valid,
    output logic [7:0]             m_arg_byte,
    output logic                   m_arg_end,
    output logic                   m_command_end,
    output logic [ARG_NUM_W-1:0]   m_arg_number,
    output logic                   m_protocol_error,
    output logic                   m_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    push_t              push;
    item_t              head;
    logic [LEVEL_W-1:0] level;
    logic               accept;
    logic               pop;

    assign s_ready   = (level + LEVEL_W'(push.count)) <= READY_LIMIT;
    assign accept    = s_valid && s_ready;
    assign m_valid   = level != '0;
    assign pop       = m_valid && m_ready;
    assign cfg_ready = 1'b1;

    rrp_parse_core #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .s_stream_byte    (s_stream_byte),
        .s_new_connection (s_new_connection),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push)
    );

    rrp_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .level   (level),
        .head    (head)
    );

    assign m_arg_byte_valid = head.arg_byte_valid;
    assign m_arg_byte       = head.arg_byte;
    assign m_arg_end        = head.arg_end;
    assign m_command_end    = head.command_end;
    assign m_arg_number     = head.arg_number;
    assign m_protocol_error = head.protocol_error;
    assign m_last           = head.last;

endmodule

/* rtl/rrp_parse_core.sv */
module rrp_parse_core
    import rrp_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             s_stream_byte,
    input  logic                   s_new_connection,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output push_t                  push
);

    localparam int NUM_BITS = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
    localparam int WIDE_W   = (NUM_BITS > CFG_DATA_W) ? NUM_BITS : CFG_DATA_W;
    localparam int ACC_W    = WIDE_W + 4;
    localparam int EXT_W    = (COUNT_BITS > ARG_NUM_W) ? COUNT_BITS : ARG_NUM_W;

    localparam logic [ACC_W-1:0] CNT_MASK = ACC_W'({COUNT_BITS{1'b1}});
    localparam logic [ACC_W-1:0] LEN_MASK = ACC_W'({LENGTH_BITS{1'b1}});

    localparam logic [COUNT_BITS-1:0]  CNT_ONE = COUNT_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_INL_CR0     = 4'd1;
    localparam logic [3:0] PH_INL_BODY    = 4'd2;
    localparam logic [3:0] PH_ARR_COUNT   = 4'd3;
    localparam logic [3:0] PH_BULK_PREFIX = 4'd4;
    localparam logic [3:0] PH_BULK_LEN    = 4'd5;
    localparam logic [3:0] PH_BULK_DATA   = 4'd6;
    localparam logic [3:0] PH_BULK_CR     = 4'd7;
    localparam logic [3:0] PH_BULK_LF     = 4'd8;

    localparam logic [1:0] NUM_GO    = 2'd0;
    localparam logic [1:0] NUM_FAULT = 2'd1;
    localparam logic [1:0] NUM_DONE  = 2'd2;

    typedef struct packed {
        logic [1:0]          code;
        logic [NUM_BITS-1:0] acc;
        logic                pcr;
        logic                ds;
    } num_t;

    typedef struct packed {
        logic  emit;
        item_t item;
        logic  bump;
        logic  set_cr;
    } inl_t;

    function automatic logic [ACC_W-1:0] clip(input logic [ACC_W-1:0] v,
                                              input logic [ACC_W-1:0] m);
        return (v < m) ? v : m;
    endfunction

    function automatic logic [ARG_NUM_W-1:0] to_num(input logic [COUNT_BITS-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[ARG_NUM_W-1:0];
    endfunction

    function automatic item_t mk_item(input logic valid, input logic [7:0] b,
                                      input logic aend, input logic cend,
                                      input logic [ARG_NUM_W-1:0] num, input logic err);
        item_t it;
        it.arg_byte_valid = valid;
        it.arg_byte       = b;
        it.arg_end        = aend;
        it.command_end    = cend;
        it.arg_number     = num;
        it.protocol_error = err;
        it.last           = 1'b0;
        return it;
    endfunction

    function automatic inl_t inline_step(input logic [7:0] b,
                                         input logic [COUNT_BITS-1:0] ac);
        inl_t r;
        r = '0;
        if (b == CH_SPACE) begin
            r.emit = 1'b1;
            r.item = mk_item(1'b0, 8'd0, 1'b1, 1'b0, to_num(ac), 1'b0);
            r.bump = 1'b1;
        end else if (b == CH_CR) begin
            r.set_cr = 1'b1;
        end else begin
            r.emit = 1'b1;
            r.item = mk_item(1'b1, b, 1'b0, 1'b0, to_num(ac), 1'b0);
        end
        return r;
    endfunction

    function automatic num_t number_step(input logic [7:0] b,
                                         input logic [ACC_W-1:0] limit,
                                         input logic [NUM_BITS-1:0] acc,
                                         input logic pcr, input logic ds);
        num_t r;
        logic [ACC_W-1:0] wide;
        logic [ACC_W-1:0] prod;
        r.code = NUM_GO;
        r.acc  = acc;
        r.pcr  = pcr;
        r.ds   = ds;
        wide   = ACC_W'(acc);
        prod   = (wide << 3) + (wide << 1) + ACC_W'(b - CH_ZERO);
        if (pcr) begin
            r.pcr  = 1'b0;
            r.code = (b == CH_LF) ? NUM_DONE : NUM_FAULT;
        end else if (b == CH_CR) begin
            if (!ds) begin
                r.code = NUM_FAULT;
            end else begin
                r.pcr = 1'b1;
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (prod > limit) begin
                r.code = NUM_FAULT;
            end else begin
                r.acc = prod[NUM_BITS-1:0];
                r.ds  = 1'b1;
            end
        end else begin
            r.code = NUM_FAULT;
        end
        return r;
    endfunction

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_newconn_reg;
    logic [ACC_W-1:0]       lim_arg_reg;
    logic [ACC_W-1:0]       lim_len_reg;
    logic [3:0]             phase_reg, phase_next;
    logic [NUM_BITS-1:0]    accum_reg, accum_next;
    logic [COUNT_BITS-1:0]  args_rem_reg, args_rem_next;
    logic [LENGTH_BITS-1:0] bytes_rem_reg, bytes_rem_next;
    logic [COUNT_BITS-1:0]  arg_cnt_reg, arg_cnt_next;
    logic                   pcr_reg, pcr_next;
    logic                   ds_reg, ds_next;
    logic                   err_reg, err_next;

    item_t      items [2];
    logic [1:0] n;
    logic       fault;
    logic       to_idle;
    logic       lidx;
    num_t       nr;
    inl_t       inl;

    always_ff @(posedge aclk) begin
        in_byte_reg    <= s_stream_byte;
        in_newconn_reg <= s_new_connection;
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            lim_arg_reg   <= clip(ACC_W'(MAX_ARG_COUNT_RST), CNT_MASK);
            lim_len_reg   <= clip(ACC_W'(MAX_BULK_LENGTH_RST), LEN_MASK);
            phase_reg     <= PH_IDLE;
            accum_reg     <= '0;
            args_rem_reg  <= '0;
            bytes_rem_reg <= '0;
            arg_cnt_reg   <= '0;
            pcr_reg       <= 1'b0;
            ds_reg        <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= accept;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            args_rem_reg  <= args_rem_next;
            bytes_rem_reg <= bytes_rem_next;
            arg_cnt_reg   <= arg_cnt_next;
            pcr_reg       <= pcr_next;
            ds_reg        <= ds_next;
            err_reg       <= err_next;
            if (cfg_valid && cfg_index == REG_MAX_ARG_COUNT) begin
                lim_arg_reg <= clip(ACC_W'(cfg_data[15:0]), CNT_MASK);
            end
            if (cfg_valid && cfg_index == REG_MAX_BULK_LENGTH) begin
                lim_len_reg <= clip(ACC_W'(cfg_data), LEN_MASK);
            end
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        args_rem_next  = args_rem_reg;
        bytes_rem_next = bytes_rem_reg;
        arg_cnt_next   = arg_cnt_reg;
        pcr_next       = pcr_reg;
        ds_next        = ds_reg;
        err_next       = err_reg;
        items[0]       = '0;
        items[1]       = '0;
        n              = 2'd0;
        fault          = 1'b0;
        to_idle        = 1'b0;
        lidx           = 1'b0;
        nr             = '0;
        inl            = '0;

        if (in_valid_reg && in_newconn_reg) begin
            phase_next     = PH_IDLE;
            accum_next     = '0;
            args_rem_next  = '0;
            bytes_rem_next = '0;
            arg_cnt_next   = '0;
            pcr_next       = 1'b0;
            ds_next        = 1'b0;
            err_next       = 1'b0;
        end

        if (in_valid_reg && !err_next) begin
            case (phase_next)
                PH_IDLE: begin
                    arg_cnt_next = '0;
                    if (in_byte_reg == CH_STAR) begin
                        phase_next = PH_ARR_COUNT;
                        accum_next = '0;
                        ds_next    = 1'b0;
                        pcr_next   = 1'b0;
                    end else if (in_byte_reg == CH_CR) begin
                        phase_next = PH_INL_CR0;
                    end else begin
                        phase_next = PH_INL_BODY;
                        pcr_next   = 1'b0;
                        inl = inline_step(in_byte_reg, arg_cnt_next);
                        if (inl.emit) begin
                            items[n[0]] = inl.item;
                            n = n + 2'd1;
                        end
                        if (inl.bump) arg_cnt_next = arg_cnt_next + CNT_ONE;
                        if (inl.set_cr) pcr_next = 1'b1;
                    end
                end
                PH_INL_CR0: begin
                    if (in_byte_reg == CH_LF) begin
                        items[0] = mk_item(1'b0, 8'd0, 1'b0, 1'b1, '0, 1'b0);
                        n        = 2'd1;
                        to_idle  = 1'b1;
                    end else begin
                        phase_next = PH_INL_BODY;
                        items[0] = mk_item(1'b1, CH_CR, 1'b0, 1'b0, to_num(arg_cnt_next), 1'b0);
                        n        = 2'd1;
                        inl = inline_step(in_byte_reg, arg_cnt_next);
                        if (inl.emit) begin
                            items[n[0]] = inl.item;
                            n = n + 2'd1;
                        end
                        if (inl.bump) arg_cnt_next = arg_cnt_next + CNT_ONE;
                        if (inl.set_cr) pcr_next = 1'b1;
                    end
                end
                PH_INL_BODY: begin
                    if (pcr_next) begin
                        pcr_next = 1'b0;
                        if (in_byte_reg == CH_LF) begin
                            items[0] = mk_item(1'b0, 8'd0, 1'b1, 1'b0,
                                               to_num(arg_cnt_next), 1'b0);
                            arg_cnt_next = arg_cnt_next + CNT_ONE;
                            items[1] = mk_item(1'b0, 8'd0, 1'b0, 1'b1,
                                               to_num(arg_cnt_next), 1'b0);
                            n        = 2'd2;
                            to_idle  = 1'b1;
                        end else begin
                            items[0] = mk_item(1'b1, CH_CR, 1'b0, 1'b0,
                                               to_num(arg_cnt_next), 1'b0);
                            n = 2'd1;
                            inl = inline_step(in_byte_reg, arg_cnt_next);
                            if (inl.emit) begin
                                items[n[0]] = inl.item;
                                n = n + 2'd1;
                            end
                            if (inl.bump) arg_cnt_next = arg_cnt_next + CNT_ONE;
                            if (inl.set_cr) pcr_next = 1'b1;
                        end
                    end else begin
                        inl = inline_step(in_byte_reg, arg_cnt_next);
                        if (inl.emit) begin
                            items[n[0]] = inl.item;
                            n = n + 2'd1;
                        end
                        if (inl.bump) arg_cnt_next = arg_cnt_next + CNT_ONE;
                        if (inl.set_cr) pcr_next = 1'b1;
                    end
                end
                PH_ARR_COUNT: begin
                    nr = number_step(in_byte_reg, lim_arg_reg, accum_next, pcr_next, ds_next);
                    accum_next = nr.acc;
                    pcr_next   = nr.pcr;
                    ds_next    = nr.ds;
                    if (nr.code == NUM_FAULT) begin
                        fault = 1'b1;
                    end else if (nr.code == NUM_DONE) begin
                        if (nr.acc == '0) begin
                            items[0] = mk_item(1'b0, 8'd0, 1'b0, 1'b1, '0, 1'b0);
                            n        = 2'd1;
                            to_idle  = 1'b1;
                        end else begin
                            args_rem_next = nr.acc[COUNT_BITS-1:0];
                            arg_cnt_next  = '0;
                            phase_next    = PH_BULK_PREFIX;
                        end
                    end
                end
                PH_BULK_PREFIX: begin
                    if (in_byte_reg == CH_DOLLAR) begin
                        phase_next = PH_BULK_LEN;
                        accum_next = '0;
                        ds_next    = 1'b0;
                        pcr_next   = 1'b0;
                    end else begin
                        fault = 1'b1;
                    end
                end
                PH_BULK_LEN: begin
                    nr = number_step(in_byte_reg, lim_len_reg, accum_next, pcr_next, ds_next);
                    accum_next = nr.acc;
                    pcr_next   = nr.pcr;
                    ds_next    = nr.ds;
                    if (nr.code == NUM_FAULT) begin
                        fault = 1'b1;
                    end else if (nr.code == NUM_DONE) begin
                        bytes_rem_next = nr.acc[LENGTH_BITS-1:0];
                        phase_next = (nr.acc[LENGTH_BITS-1:0] == '0) ? PH_BULK_CR
                                                                     : PH_BULK_DATA;
                    end
                end
                PH_BULK_DATA: begin
                    items[0] = mk_item(1'b1, in_byte_reg, 1'b0, 1'b0,
                                       to_num(arg_cnt_next), 1'b0);
                    n = 2'd1;
                    bytes_rem_next = bytes_rem_next - LEN_ONE;
                    if (bytes_rem_next == '0) phase_next = PH_BULK_CR;
                end
                PH_BULK_CR: begin
                    if (in_byte_reg == CH_CR) begin
                        phase_next = PH_BULK_LF;
                    end else begin
                        fault = 1'b1;
                    end
                end
                PH_BULK_LF: begin
                    if (in_byte_reg != CH_LF) begin
                        fault = 1'b1;
                    end else begin
                        items[0] = mk_item(1'b0, 8'd0, 1'b1, 1'b0,
                                           to_num(arg_cnt_next), 1'b0);
                        n = 2'd1;
                        arg_cnt_next  = arg_cnt_next + CNT_ONE;
                        args_rem_next = args_rem_next - CNT_ONE;
                        if (args_rem_next == '0) begin
                            items[1] = mk_item(1'b0, 8'd0, 1'b0, 1'b1,
                                               to_num(arg_cnt_next), 1'b0);
                            n       = 2'd2;
                            to_idle = 1'b1;
                        end else begin
                            phase_next = PH_BULK_PREFIX;
                        end
                    end
                end
                default: begin
                    to_idle = 1'b1;
                end
            endcase

            if (fault) begin
                to_idle  = 1'b1;
                err_next = 1'b1;
                items[0] = mk_item(1'b0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                items[1] = '0;
                n        = 2'd1;
            end
            if (to_idle) begin
                phase_next     = PH_IDLE;
                accum_next     = '0;
                args_rem_next  = '0;
                bytes_rem_next = '0;
                arg_cnt_next   = '0;
                pcr_next       = 1'b0;
                ds_next        = 1'b0;
            end
            if (n != 2'd0) begin
                lidx = n[0] ? 1'b0 : 1'b1;
                items[lidx].last = 1'b1;
            end
        end

        push.count = n;
        push.item0 = items[0];
        push.item1 = items[1];
    end

endmodule

/* rtl/rrp_out_fifo.sv */
module rrp_out_fifo
    import rrp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  push_t              push,
    input  logic               pop,
    output logic [LEVEL_W-1:0] level,
    output item_t              head
);

    item_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        level_next  = level_reg + LEVEL_W'(push.count) - LEVEL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.item1;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign level = level_reg;
    assign head  = mem[rd_ptr_reg];

endmodule

/* rtl/rrp_checker.sv */
module rrp_checker
    import rrp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_arg_byte_valid,
    input logic [7:0]           m_arg_byte,
    input logic                 m_arg_end,
    input logic                 m_command_end,
    input logic [ARG_NUM_W-1:0] m_arg_number,
    input logic                 m_protocol_error,
    input logic                 m_last
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_arg_byte) && $stable(m_arg_number)
            && $stable(m_last) && $stable(m_protocol_error))
        else $error("result payload changed while stalled");

    // An error report is the only item of its byte and carries no other marks.
    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_protocol_error |-> m_last && !m_arg_byte_valid && !m_arg_end
            && !m_command_end && m_arg_number == '0)
        else $error("malformed protocol error item");

    a_end_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_end |-> !m_arg_end && !m_arg_byte_valid && m_last)
        else $error("command end item carries other marks");

    a_byte_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arg_byte_valid |-> !m_arg_end && !m_command_end)
        else $error("content byte item carries end marks");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result queue not empty after reset");

endmodule

bind resp_request_parser_unit rrp_checker u_chk (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import rrp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 40;

    typedef enum logic [3:0] {
        PS_IDLE,
        PS_INL_CR0,
        PS_INL_BODY,
        PS_ARR_COUNT,
        PS_BULK_PREFIX,
        PS_BULK_LEN,
        PS_BULK_DATA,
        PS_BULK_CR,
        PS_BULK_LF
    } parse_phase_t;

    typedef enum int {LINE_MORE, LINE_BAD, LINE_DONE} line_status_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SCRAMBLE,
        FLAW_BIG_COUNT,
        FLAW_BIG_LENGTH,
        FLAW_NO_DIGITS
    } flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       reconnect;
    } stream_in_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_stream_byte = '0;
    logic                   s_new_connection = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_arg_byte_valid;
    logic [7:0]             m_arg_byte;
    logic                   m_arg_end;
    logic                   m_command_end;
    logic [ARG_NUM_W-1:0]   m_arg_number;
    logic                   m_protocol_error;
    logic                   m_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    resp_request_parser_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .s_new_connection (s_new_connection),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_arg_byte_valid (m_arg_byte_valid),
        .m_arg_byte       (m_arg_byte),
        .m_arg_end        (m_arg_end),
        .m_command_end    (m_command_end),
        .m_arg_number     (m_arg_number),
        .m_protocol_error (m_protocol_error),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Parser state mirrored by the predictor.
    logic [15:0]     cap_count;
    logic [31:0]     cap_len;
    parse_phase_t    parse_phase;
    longint unsigned num_acc;
    logic [15:0]     args_left;
    logic [31:0]     bytes_left;
    logic [15:0]     arg_idx;
    bit              cr_pending;
    bit              have_digit;
    bit              err_latched;

    item_t      step_items[$];
    item_t      result_q[$];
    stream_in_t stream_q[$];
    logic [7:0] cmd_bytes[$];

    bit          byte_taken = 0;
    bit          reconnect_pending = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_left = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_checked = 0;
    int unsigned commands_seen = 0;
    int unsigned faults_seen = 0;
    int unsigned mismatches = 0;

    task automatic clear_parse();
        parse_phase = PS_IDLE;
        num_acc = 0;
        args_left = '0;
        bytes_left = '0;
        arg_idx = '0;
        cr_pending = 0;
        have_digit = 0;
    endtask

    task automatic start_number();
        num_acc = 0;
        have_digit = 0;
        cr_pending = 0;
    endtask

    task automatic emit(bit valid, logic [7:0] data, bit aend, bit cend, logic [15:0] num,
                        bit err);
        item_t it;
        it = '0;
        it.arg_byte_valid = valid;
        it.arg_byte = data;
        it.arg_end = aend;
        it.command_end = cend;
        it.arg_number = num;
        it.protocol_error = err;
        step_items.insert(step_items.size(), it);
    endtask

    task automatic inline_char(logic [7:0] b);
        if (b == CH_SPACE) begin
            emit(0, '0, 1, 0, arg_idx, 0);
            arg_idx++;
        end else if (b == CH_CR) begin
            cr_pending = 1;
        end else begin
            emit(1, b, 0, 0, arg_idx, 0);
        end
    endtask

    function automatic line_status_t take_digit(logic [7:0] b, longint unsigned limit);
        longint unsigned d;
        if (cr_pending) begin
            cr_pending = 0;
            return (b == CH_LF) ? LINE_DONE : LINE_BAD;
        end
        if (b == CH_CR) begin
            if (!have_digit) return LINE_BAD;
            cr_pending = 1;
            return LINE_MORE;
        end
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = 64'(b - CH_ZERO);
            if (d > limit || num_acc > (limit - d) / 10) return LINE_BAD;
            num_acc = num_acc * 10 + d;
            have_digit = 1;
            return LINE_MORE;
        end
        return LINE_BAD;
    endfunction

    // Works out the result items of one accepted stream byte.
    task automatic parse_byte(logic [7:0] b, logic reconnect);
        line_status_t st;
        bit fault;
        fault = 0;
        step_items.delete();
        if (reconnect) begin
            clear_parse();
            err_latched = 0;
        end
        if (err_latched) return;
        case (parse_phase)
            PS_IDLE: begin
                arg_idx = '0;
                if (b == CH_STAR) begin
                    parse_phase = PS_ARR_COUNT;
                    start_number();
                end else if (b == CH_CR) begin
                    parse_phase = PS_INL_CR0;
                end else begin
                    parse_phase = PS_INL_BODY;
                    cr_pending = 0;
                    inline_char(b);
                end
            end
            PS_INL_CR0: begin
                if (b == CH_LF) begin
                    emit(0, '0, 0, 1, '0, 0);
                    clear_parse();
                end else begin
                    parse_phase = PS_INL_BODY;
                    emit(1, CH_CR, 0, 0, arg_idx, 0);
                    inline_char(b);
                end
            end
            PS_INL_BODY: begin
                if (cr_pending) begin
                    cr_pending = 0;
                    if (b == CH_LF) begin
                        emit(0, '0, 1, 0, arg_idx, 0);
                        arg_idx++;
                        emit(0, '0, 0, 1, arg_idx, 0);
                        clear_parse();
                    end else begin
                        emit(1, CH_CR, 0, 0, arg_idx, 0);
                        inline_char(b);
                    end
                end else begin
                    inline_char(b);
                end
            end
            PS_ARR_COUNT: begin
                st = take_digit(b, longint'(cap_count));
                if (st == LINE_BAD) begin
                    fault = 1;
                end else if (st == LINE_DONE) begin
                    if (num_acc == 0) begin
                        emit(0, '0, 0, 1, '0, 0);
                        clear_parse();
                    end else begin
                        args_left = num_acc[15:0];
                        arg_idx = '0;
                        parse_phase = PS_BULK_PREFIX;
                    end
                end
            end
            PS_BULK_PREFIX: begin
                if (b == CH_DOLLAR) begin
                    parse_phase = PS_BULK_LEN;
                    start_number();
                end else begin
                    fault = 1;
                end
            end
            PS_BULK_LEN: begin
                st = take_digit(b, longint'(cap_len));
                if (st == LINE_BAD) begin
                    fault = 1;
                end else if (st == LINE_DONE) begin
                    bytes_left = num_acc[31:0];
                    parse_phase = (bytes_left == 0) ? PS_BULK_CR : PS_BULK_DATA;
                end
            end
            PS_BULK_DATA: begin
                emit(1, b, 0, 0, arg_idx, 0);
                bytes_left--;
                if (bytes_left == 0) parse_phase = PS_BULK_CR;
            end
            PS_BULK_CR: begin
                if (b == CH_CR) parse_phase = PS_BULK_LF;
                else fault = 1;
            end
            PS_BULK_LF: begin
                if (b != CH_LF) begin
                    fault = 1;
                end else begin
                    emit(0, '0, 1, 0, arg_idx, 0);
                    arg_idx++;
                    args_left--;
                    if (args_left == 0) begin
                        emit(0, '0, 0, 1, arg_idx, 0);
                        clear_parse();
                    end else begin
                        parse_phase = PS_BULK_PREFIX;
                    end
                end
            end
            default: clear_parse();
        endcase
        if (fault) begin
            clear_parse();
            err_latched = 1;
            step_items.delete();
            emit(0, '0, 0, 0, '0, 1);
        end
        if (step_items.size() > 0) begin
            step_items[step_items.size() - 1].last = 1'b1;
        end
        foreach (step_items[i]) result_q.insert(result_q.size(), step_items[i]);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Input side: one stream byte per transaction.
    always @(negedge aclk) begin
        stream_in_t head;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            byte_taken = 0;
            if (stream_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                head = stream_q.pop_front();
                s_valid <= 1'b1;
                s_stream_byte <= head.data;
                s_new_connection <= head.reconnect;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        item_t want;
        cycle_count++;
        if (aresetn && s_valid && s_ready) begin
            parse_byte(s_stream_byte, s_new_connection);
            byte_taken = 1;
            bytes_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected, expected none, actual %h %h %b",
                             $time, m_arg_byte, m_arg_number,
                             {m_arg_byte_valid, m_arg_end, m_command_end, m_protocol_error,
                              m_last});
            end else begin
                want = result_q.pop_front();
                check_field("arg_byte_valid", want.arg_byte_valid, m_arg_byte_valid);
                check_field("arg_byte", want.arg_byte, m_arg_byte);
                check_field("arg_end", want.arg_end, m_arg_end);
                check_field("command_end", want.command_end, m_command_end);
                check_field("arg_number", want.arg_number, m_arg_number);
                check_field("protocol_error", want.protocol_error, m_protocol_error);
                check_field("last", want.last, m_last);
                results_checked++;
                if (want.command_end) commands_seen++;
                if (want.protocol_error) faults_seen++;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic push_byte(logic [7:0] b);
        stream_in_t e;
        e.data = b;
        e.reconnect = reconnect_pending;
        stream_q.insert(stream_q.size(), e);
        reconnect_pending = 0;
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic append_cmd(logic [7:0] b);
        cmd_bytes.insert(cmd_bytes.size(), b);
    endtask

    task automatic add_decimal(longint unsigned v);
        logic [7:0] digits[$];
        int unsigned zeros;
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        repeat (zeros) digits.push_front(CH_ZERO);
        foreach (digits[i]) append_cmd(digits[i]);
    endtask

    task automatic gen_array(flaw_t flaw);
        int unsigned n_args;
        int unsigned len;
        int unsigned len_cap;
        cmd_bytes.delete();
        append_cmd(CH_STAR);
        n_args = $urandom_range(0, (cap_count < 4) ? cap_count : 4);
        if ($urandom_range(0, 15) == 0)
            n_args = $urandom_range(0, (cap_count < 12) ? cap_count : 12);
        case (flaw)
            FLAW_BIG_COUNT: add_decimal(longint'(cap_count) + 1 + $urandom_range(0, 9));
            FLAW_NO_DIGITS: n_args = 0;
            FLAW_BIG_LENGTH: begin
                n_args = 1;
                add_decimal(1);
            end
            default: add_decimal(n_args);
        endcase
        append_cmd(CH_CR);
        append_cmd(CH_LF);
        if (flaw == FLAW_BIG_COUNT) n_args = 0;
        for (int a = 0; a < n_args; a++) begin
            append_cmd(CH_DOLLAR);
            if (flaw == FLAW_BIG_LENGTH) begin
                len = 0;
                add_decimal(longint'(cap_len) + 1 + $urandom_range(0, 9));
            end else begin
                len_cap = ($urandom_range(0, 9) == 0) ? 24 : 6;
                len = $urandom_range(0, (cap_len < len_cap) ? cap_len : len_cap);
                add_decimal(len);
            end
            append_cmd(CH_CR);
            append_cmd(CH_LF);
            repeat (len) append_cmd(8'($urandom_range(0, 255)));
            append_cmd(CH_CR);
            append_cmd(CH_LF);
        end
        if (flaw == FLAW_SCRAMBLE)
            cmd_bytes[$urandom_range(1, cmd_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        foreach (cmd_bytes[i]) push_byte(cmd_bytes[i]);
        if (flaw != FLAW_NONE) reconnect_pending = 1;
    endtask

    task automatic gen_inline();
        int unsigned n_tok;
        int unsigned len;
        logic [7:0] c;
        n_tok = $urandom_range(0, 4);
        for (int t = 0; t < n_tok; t++) begin
            if (t > 0) push_byte(CH_SPACE);
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) begin
                c = 8'($urandom_range(0, 255));
                if (t == 0 && k == 0 && c == CH_STAR) c = CH_SPACE;
                push_byte(c);
                if (c == CH_CR) push_byte(CH_SPACE);
            end
        end
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic gen_commands(int unsigned n);
        int unsigned target;
        int unsigned pick;
        target = bytes_queued + n;
        while (bytes_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                gen_array(FLAW_NONE);
            end else if (pick < 75) begin
                gen_inline();
            end else if (pick < 90) begin
                gen_array(flaw_t'($urandom_range(FLAW_SCRAMBLE, FLAW_NO_DIGITS)));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0) reconnect_pending = 1;
                    push_byte(8'($urandom_range(0, 255)));
                end
                reconnect_pending = 1;
            end else begin
                reconnect_pending = 1;
            end
        end
    endtask

    task automatic wait_quiet();
        while (stream_q.size() != 0 || s_valid || result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MAX_ARG_COUNT: cap_count = val[15:0];
            REG_MAX_BULK_LENGTH: cap_len = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned n, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        gen_commands(n);
        wait_quiet();
    endtask

    initial begin
        cap_count = MAX_ARG_COUNT_RST;
        cap_len = MAX_BULK_LENGTH_RST;
        clear_parse();
        err_latched = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty inline line, empty array, lone carriage returns with an empty
        // token, a bulk argument with an all-ones byte followed by a bad prefix,
        // a byte dropped while the error is latched, and a reconnect.
        push_text("\r\n");
        push_text("*0\r\n");
        push_text("\rx\r \r\n");
        push_text("*2\r\n$1\r\n");
        push_byte(8'hFF);
        push_text("\r\n%z");
        reconnect_pending = 1;
        push_byte(8'h00);
        reconnect_pending = 1;
        run_phase(450, 0, 0);

        write_limit(REG_MAX_ARG_COUNT, 32'd3);
        write_limit(REG_MAX_BULK_LENGTH, 32'd5);
        run_phase(350, 86, 0);

        write_limit(REG_MAX_ARG_COUNT, 32'd0);
        write_limit(REG_MAX_BULK_LENGTH, 32'd0);
        run_phase(250, 0, 86);

        write_limit(REG_MAX_ARG_COUNT, 32'd65535);
        write_limit(REG_MAX_BULK_LENGTH, 32'hFFFF_FFFF);
        run_phase(350, 36, 36);

        write_limit(REG_MAX_ARG_COUNT, 32'(MAX_ARG_COUNT_RST));
        write_limit(REG_MAX_BULK_LENGTH, MAX_BULK_LENGTH_RST);
        hold_off_left = 400;
        run_phase(450, 0, 0);

        $display("Parsed %0d stream bytes under five limit settings and idle patterns.",
                 bytes_taken);
        $display("Checked %0d result items: %0d command ends, %0d protocol errors.",
                 results_checked, commands_seen, faults_seen);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
